// File: sv/rasr_pkg.sv
// ----------------------------------------------------------------------------
// rasr_pkg
// Shared constants for the rational add / subtract / reduce block.
// ----------------------------------------------------------------------------
package rasr_pkg;

  localparam int unsigned WordBitsDef = 32;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // divider unit operation codes
  localparam logic [1:0] DOP_DIV = 2'd0;
  localparam logic [1:0] DOP_MUL = 2'd1;

endpackage

// File: sv/rasr_alu.sv
// ----------------------------------------------------------------------------
// rasr_alu
// Shared multi-cycle unit: unsigned restoring divide (one quotient bit per
// cycle) or shift-add multiply (one multiplier bit per cycle), 32-bit operands.
// ----------------------------------------------------------------------------
module rasr_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [63:0] res_o,   // quotient in low half for divide, product for multiply
  output logic [31:0] rem_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [1:0]  op_q, op_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] b_q, b_d;
  logic [31:0] a_q, a_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    b_d    = b_q;
    a_d    = a_q;
    done_d = 1'b0;
    trial  = {rem_q, a_q[31]} - {1'b0, b_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      op_d   = op_i;
      acc_d  = '0;
      rem_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
    end else if (busy_q) begin
      if (op_q == rasr_pkg::DOP_MUL) begin
        if (a_q[31]) begin
          acc_d = {acc_q[62:0], 1'b0} + {32'd0, b_q};
        end else begin
          acc_d = {acc_q[62:0], 1'b0};
        end
      end else begin
        // remainder stays below the divisor, so it fits 32 bits
        if (!trial[32]) begin
          rem_d = trial[31:0];
          acc_d = {acc_q[62:0], 1'b1};
        end else begin
          rem_d = {rem_q[30:0], a_q[31]};
          acc_d = {acc_q[62:0], 1'b0};
        end
      end
      a_d   = {a_q[30:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;
  assign rem_o  = rem_q;

endmodule

// File: sv/rational_add_sub_reduce_top.sv
// ----------------------------------------------------------------------------
// rational_add_sub_reduce_top
// Signed fraction add / subtract / reduce with Euclidean GCD reduction.
// ----------------------------------------------------------------------------
// channel   dir  tdata (low bit up)                           tuser
// s_axis    in   first_num, first_den, second_num, second_den  mode
// m_axis    out  result_num, result_den, pad                   status
//
// one word at a time; every divide or multiply runs on the shared unit, so
// an add or subtract runs four gcds plus twelve further divides or multiplies
// and a reduce one gcd plus two divides; a zero or out-of-range operand is
// answered straight from idle without using the shared unit.
// Euclid steps depend on the operands (at most about 46 per gcd).
// reset clears the sequencer; s_axis_tready is high only when idle and the
// output register is empty, a stalled result holds in the output register.
module rational_add_sub_reduce_top #(
  parameter int unsigned WORD_BITS = rasr_pkg::WordBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // first_num, first_den, second_num, second_den
  input  logic [1:0]   s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // result_num, result_den, zero pad
  output logic [1:0]   m_axis_tuser   // status
);

  localparam logic [31:0] LimW = (WORD_BITS >= 32) ? 32'h7FFF_FFFF :
                                 32'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic [63:0] Lim  = {32'd0, LimW};

  localparam logic [4:0] S_IDLE = 5'd0,  S_G1   = 5'd1,  S_G1W  = 5'd2,
                         S_N1A  = 5'd3,  S_N1AW = 5'd4,  S_N1B  = 5'd5,
                         S_N1BW = 5'd6,  S_G2   = 5'd7,  S_G2W  = 5'd8,
                         S_N2A  = 5'd9,  S_N2AW = 5'd10, S_N2B  = 5'd11,
                         S_N2BW = 5'd12, S_GL   = 5'd13, S_GLW  = 5'd14,
                         S_L1   = 5'd15, S_L1W  = 5'd16, S_L2   = 5'd17,
                         S_L2W  = 5'd18, S_LM   = 5'd19, S_LMW  = 5'd20,
                         S_MA   = 5'd21, S_MAW  = 5'd22, S_MB   = 5'd23,
                         S_MBW  = 5'd24, S_SUM  = 5'd25, S_GF   = 5'd26,
                         S_GFW  = 5'd27, S_FN   = 5'd28, S_FNW  = 5'd29,
                         S_FD   = 5'd30, S_FDW  = 5'd31;

  logic [4:0]  st_q, st_d;
  logic [4:0]  ret_q, ret_d;          // state to resume after a gcd
  logic        two_q, two_d, sub_q, sub_d;
  logic [31:0] n1_q, n1_d, d1_q, d1_d, n2_q, n2_d, d2_q, d2_d;
  logic        s1_q, s1_d, s2_q, s2_d;
  logic [31:0] ga_q, ga_d, gb_q, gb_d, g_q, g_d, t_q, t_d, l_q, l_d;
  logic [31:0] ss_q, ss_d;             // magnitude of sum
  logic        ssn_q, ssn_d;
  logic        ov_q, ov_d;
  logic [31:0] o_n_q, o_n_d;
  logic [30:0] o_d_q, o_d_d;
  logic [1:0]  o_s_q, o_s_d;
  logic        ov_out_q, ov_out_d;

  logic        u_start;
  logic [1:0]  u_op;
  logic [31:0] u_a, u_b, u_rem;
  logic [63:0] u_res;
  logic        u_done;

  rasr_alu u_alu (
    .clk_i, .rst_ni, .start_i(u_start), .op_i(u_op), .a_i(u_a), .b_i(u_b),
    .done_o(u_done), .res_o(u_res), .rem_o(u_rem)
  );

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? (~v + 32'd1) : v;
  endfunction

  logic [31:0] in_n1, in_d1, in_n2, in_d2;
  logic [33:0] sa, sb, sum;

  assign in_n1 = s_axis_tdata[31:0];
  assign in_d1 = s_axis_tdata[63:32];
  assign in_n2 = s_axis_tdata[95:64];
  assign in_d2 = s_axis_tdata[127:96];
  assign s_axis_tready = (st_q == S_IDLE) && !ov_out_q;

  always_comb begin
    st_d = st_q; ret_d = ret_q; two_d = two_q; sub_d = sub_q;
    n1_d = n1_q; d1_d = d1_q; n2_d = n2_q; d2_d = d2_q;
    s1_d = s1_q; s2_d = s2_q;
    ga_d = ga_q; gb_d = gb_q; g_d = g_q; t_d = t_q; l_d = l_q;
    ss_d = ss_q; ssn_d = ssn_q; ov_d = ov_q;
    o_n_d = o_n_q; o_d_d = o_d_q; o_s_d = o_s_q; ov_out_d = ov_out_q;
    u_start = 1'b0; u_op = rasr_pkg::DOP_DIV; u_a = ga_q; u_b = gb_q;
    sa = '0; sb = '0; sum = '0;
    if (ov_out_q && m_axis_tready) ov_out_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          two_d = (s_axis_tuser == rasr_pkg::MODE_ADD) ||
                  (s_axis_tuser == rasr_pkg::MODE_SUB);
          sub_d = (s_axis_tuser == rasr_pkg::MODE_SUB);
          n1_d = mag(in_n1); d1_d = mag(in_d1);
          n2_d = mag(in_n2); d2_d = mag(in_d2);
          s1_d = (in_n1 != 32'd0) && (in_n1[31] != in_d1[31]);
          s2_d = (in_n2 != 32'd0) && (in_n2[31] != in_d2[31]);
          o_n_d = '0; o_d_d = 31'd1;
          if (in_d1 == 32'd0 || (two_d && in_d2 == 32'd0)) begin
            o_s_d = rasr_pkg::ST_ZERO; ov_out_d = 1'b1;
          end else if (mag(in_n1) > LimW || mag(in_d1) > LimW ||
                       (two_d && (mag(in_n2) > LimW || mag(in_d2) > LimW))) begin
            o_s_d = rasr_pkg::ST_OVF; ov_out_d = 1'b1;
          end else begin
            ga_d = mag(in_n1); gb_d = mag(in_d1); ret_d = S_N1A; st_d = S_G1;
          end
        end
      end
      // generic euclid loop on ga/gb, result into g
      S_G1: begin
        if (gb_q == 32'd0) begin
          g_d = ga_q; st_d = ret_q;
        end else begin
          u_start = 1'b1; st_d = S_G1W;
        end
      end
      S_G1W: if (u_done) begin ga_d = gb_q; gb_d = u_rem; st_d = S_G1; end
      S_N1A: begin u_start = 1'b1; u_a = n1_q; u_b = g_q; st_d = S_N1AW; end
      S_N1AW: if (u_done) begin n1_d = u_res[31:0]; st_d = S_N1B; end
      S_N1B: begin u_start = 1'b1; u_a = d1_q; u_b = g_q; st_d = S_N1BW; end
      S_N1BW: if (u_done) begin
        d1_d = u_res[31:0];
        if (two_q) begin
          ga_d = n2_q; gb_d = d2_q; ret_d = S_N2A; st_d = S_G1;
        end else begin
          o_n_d = s1_q ? (~n1_q + 32'd1) : n1_q; o_d_d = u_res[30:0];
          o_s_d = rasr_pkg::ST_OK; ov_out_d = 1'b1; st_d = S_IDLE;
        end
      end
      S_N2A: begin u_start = 1'b1; u_a = n2_q; u_b = g_q; st_d = S_N2AW; end
      S_N2AW: if (u_done) begin n2_d = u_res[31:0]; st_d = S_N2B; end
      S_N2B: begin u_start = 1'b1; u_a = d2_q; u_b = g_q; st_d = S_N2BW; end
      S_N2BW: if (u_done) begin
        d2_d = u_res[31:0]; ga_d = d1_q; gb_d = u_res[31:0]; ret_d = S_L1;
        st_d = S_G1;
      end
      S_L1: begin u_start = 1'b1; u_a = d1_q; u_b = g_q; st_d = S_L1W; end
      S_L1W: if (u_done) begin t_d = u_res[31:0]; st_d = S_LM; end
      S_LM: begin
        u_start = 1'b1; u_op = rasr_pkg::DOP_MUL; u_a = t_q; u_b = d2_q;
        st_d = S_LMW;
      end
      S_LMW: if (u_done) begin
        if (u_res > Lim) begin
          o_s_d = rasr_pkg::ST_OVF; ov_out_d = 1'b1; st_d = S_IDLE;
        end else begin
          l_d = u_res[31:0]; st_d = S_L2;
        end
      end
      // scale factor for a: lcm/d1
      S_L2: begin u_start = 1'b1; u_a = l_q; u_b = d1_q; st_d = S_L2W; end
      S_L2W: if (u_done) begin t_d = u_res[31:0]; st_d = S_MA; end
      S_MA: begin
        u_start = 1'b1; u_op = rasr_pkg::DOP_MUL; u_a = n1_q; u_b = t_q;
        st_d = S_MAW;
      end
      S_MAW: if (u_done) begin
        ov_d = (u_res > Lim); n1_d = u_res[31:0]; st_d = S_GL;
      end
      S_GL: begin u_start = 1'b1; u_a = l_q; u_b = d2_q; st_d = S_GLW; end
      S_GLW: if (u_done) begin t_d = u_res[31:0]; st_d = S_MB; end
      S_MB: begin
        u_start = 1'b1; u_op = rasr_pkg::DOP_MUL; u_a = n2_q; u_b = t_q;
        st_d = S_MBW;
      end
      S_MBW: if (u_done) begin
        n2_d = u_res[31:0];
        if (ov_q || u_res > Lim) begin
          o_s_d = rasr_pkg::ST_OVF; ov_out_d = 1'b1; st_d = S_IDLE;
        end else begin
          st_d = S_SUM;
        end
      end
      S_SUM: begin
        sa = s1_q ? -{2'b00, n1_q} : {2'b00, n1_q};
        sb = (s2_q ^ sub_q) ? -{2'b00, n2_q} : {2'b00, n2_q};
        sum = sa + sb;
        ssn_d = sum[33];
        ss_d = sum[33] ? 32'(-sum) : sum[31:0];
        if ((sum[33] ? 34'(-sum) : sum) > {2'b00, Lim[31:0]}) begin
          o_s_d = rasr_pkg::ST_OVF; ov_out_d = 1'b1; st_d = S_IDLE;
        end else begin
          ga_d = ss_d; gb_d = l_q; ret_d = S_FN; st_d = S_G1;
        end
      end
      S_FN: begin u_start = 1'b1; u_a = ss_q; u_b = g_q; st_d = S_FNW; end
      S_FNW: if (u_done) begin
        o_n_d = ssn_q ? (~u_res[31:0] + 32'd1) : u_res[31:0]; st_d = S_FD;
      end
      S_FD: begin u_start = 1'b1; u_a = l_q; u_b = g_q; st_d = S_FDW; end
      S_FDW: if (u_done) begin
        o_d_d = u_res[30:0]; o_s_d = rasr_pkg::ST_OK; ov_out_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_out_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_out_q <= ov_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; two_q <= two_d; sub_q <= sub_d;
    n1_q <= n1_d; d1_q <= d1_d; n2_q <= n2_d; d2_q <= d2_d;
    s1_q <= s1_d; s2_q <= s2_d;
    ga_q <= ga_d; gb_q <= gb_d; g_q <= g_d; t_q <= t_d; l_q <= l_d;
    ss_q <= ss_d; ssn_q <= ssn_d; ov_q <= ov_d;
    o_n_q <= o_n_d; o_d_q <= o_d_d; o_s_q <= o_s_d;
  end

  assign m_axis_tvalid = ov_out_q;
  assign m_axis_tdata  = {1'b0, o_d_q, o_n_q};
  assign m_axis_tuser  = o_s_q;

endmodule

// File: sim/rational_add_sub_reduce_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_add_sub_reduce_top_test
// Drives fraction add / subtract / reduce words through the stream ports and
// compares every result word with a typed expectation or a fraction predictor kept in the bench.
// ----------------------------------------------------------------------------
module rational_add_sub_reduce_top_test;

  localparam logic [1:0] MODE_RED = 2'd2;
  localparam logic [1:0] MODE_ALT = 2'd3;
  localparam longint unsigned MagMax = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  st;
  } frac_res_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] n1, d1, n2, d2;
    bit          typed;
    frac_res_t   res;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // first_num, first_den, second_num, second_den
  logic [1:0]   s_axis_tuser = '0;  // mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;       // result_num, result_den, zero pad
  logic [1:0]   m_axis_tuser;       // status

  frac_res_t sum_q[$];
  int        err_cnt = 0;
  int        src_idle = 0;
  int        snk_idle = 0;

  rational_add_sub_reduce_top DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint unsigned gcd_u(longint unsigned a, longint unsigned b);
    longint unsigned r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic bit norm_frac(longint n, longint d, output longint rn,
                                   output longint unsigned rd);
    longint unsigned un, ud, g;
    bit neg;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    neg = (n != 0) && ((n < 0) != (d < 0));
    if (un > MagMax || ud > MagMax) return 1'b0;
    g = gcd_u(un, ud);
    un /= g;
    ud /= g;
    rn = neg ? -longint'(un) : longint'(un);
    rd = ud;
    return 1'b1;
  endfunction

  function automatic frac_res_t predict_frac(logic [1:0] mode, logic [31:0] n1_w,
                                             logic [31:0] d1_w, logic [31:0] n2_w,
                                             logic [31:0] d2_w);
    longint n1, d1, n2, d2, a, b, ta, tb, s, rn;
    longint unsigned da, db, lcm, ma, mb, ms, g, rd;
    logic [1:0] st;
    bit two;
    n1 = longint'(signed'(n1_w));
    d1 = longint'(signed'(d1_w));
    n2 = longint'(signed'(n2_w));
    d2 = longint'(signed'(d2_w));
    two = (mode == rasr_pkg::MODE_ADD) || (mode == rasr_pkg::MODE_SUB);
    rn = 0;
    rd = 1;
    st = rasr_pkg::ST_OK;
    if (d1 == 0 || (two && d2 == 0)) begin
      st = rasr_pkg::ST_ZERO;
    end else if (!two) begin
      if (!norm_frac(n1, d1, rn, rd)) st = rasr_pkg::ST_OVF;
    end else if (!norm_frac(n1, d1, a, da) || !norm_frac(n2, d2, b, db)) begin
      st = rasr_pkg::ST_OVF;
    end else begin
      lcm = (da / gcd_u(da, db)) * db;
      if (lcm > MagMax) begin
        st = rasr_pkg::ST_OVF;
      end else begin
        ma = unsigned'(a < 0 ? -a : a) * (lcm / da);
        mb = unsigned'(b < 0 ? -b : b) * (lcm / db);
        if (ma > MagMax || mb > MagMax) begin
          st = rasr_pkg::ST_OVF;
        end else begin
          ta = a < 0 ? -longint'(ma) : longint'(ma);
          tb = b < 0 ? -longint'(mb) : longint'(mb);
          s = (mode == rasr_pkg::MODE_ADD) ? ta + tb : ta - tb;
          ms = s < 0 ? -s : s;
          if (ms > MagMax) begin
            st = rasr_pkg::ST_OVF;
          end else begin
            g = gcd_u(ms, lcm);
            ms /= g;
            rd = lcm / g;
            rn = s < 0 ? -longint'(ms) : longint'(ms);
          end
        end
      end
    end
    if (st != rasr_pkg::ST_OK) begin
      rn = 0;
      rd = 1;
    end
    return '{num: rn[31:0], den: rd[30:0], st: st};
  endfunction

  task automatic send_word(logic [1:0] mode, logic [31:0] n1, logic [31:0] d1,
                           logic [31:0] n2, logic [31:0] d2, frac_res_t res);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {d2, n2, d1, n1};
    s_axis_tuser = mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sum_q.push_back(res);
  endtask

  function automatic logic [31:0] rand_den(int unsigned lim);
    int v;
    v = $urandom_range(lim, 1);
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic logic [31:0] rand_val(int unsigned kind);
    int v;
    case (kind)
      0: v = $urandom_range(1000);
      1: v = $urandom_range(65535);
      2: v = $urandom_range(32'h7FFF_FFFF);
      default: return $urandom;
    endcase
    return $urandom_range(1) ? -v : v;
  endfunction

  // receiver stall pattern
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= snk_idle);

  always @(posedge clk_i) begin
    frac_res_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{num: m_axis_tdata[31:0], den: m_axis_tdata[62:32], st: m_axis_tuser};
      if (sum_q.size() == 0) begin
        $display("%0t: result word with none expected: %h", $time, got);
        err_cnt++;
      end else begin
        want = sum_q.pop_front();
        if (got !== want || m_axis_tdata[63] !== 1'b0) begin
          $display("%0t: mismatch num/den/status expected %0d/%0d/%0d actual %0d/%0d/%0d",
                   $time, signed'(want.num), want.den, want.st,
                   signed'(got.num), got.den, got.st);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #200_000_000;
    $display("rational_add_sub_reduce_top_test: errors");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    logic [1:0] md;
    logic [31:0] n1, d1, n2, d2;
    int unsigned k;
    frac_res_t exp_r;

    // directed rows; typed results only where obvious
    rows = '{
      '{rasr_pkg::MODE_ADD, 32'd1, 32'd0, 32'd1, 32'd1, 1, '{0, 1, rasr_pkg::ST_ZERO}},
      '{rasr_pkg::MODE_SUB, 32'd1, 32'd1, 32'd1, 32'd0, 1, '{0, 1, rasr_pkg::ST_ZERO}},
      '{MODE_RED, 32'd5, 32'd0, 32'd9, 32'd9, 1, '{0, 1, rasr_pkg::ST_ZERO}},
      '{MODE_RED, 32'd5, 32'd3, 32'd0, 32'd0, 1, '{5, 3, rasr_pkg::ST_OK}},
      '{MODE_ALT, 32'd4, 32'd8, 32'd0, 32'd0, 1, '{1, 2, rasr_pkg::ST_OK}},
      '{MODE_RED, 32'h8000_0000, 32'd1, 32'd0, 32'd0, 1, '{0, 1, rasr_pkg::ST_OVF}},
      '{rasr_pkg::MODE_ADD, 32'd1, 32'h8000_0000, 32'd1, 32'd1, 1,
        '{0, 1, rasr_pkg::ST_OVF}},
      '{rasr_pkg::MODE_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1, 1,
        '{0, 1, rasr_pkg::ST_OVF}},
      '{rasr_pkg::MODE_SUB, 32'h8000_0001, 32'd1, 32'd1, 32'd1, 1,
        '{0, 1, rasr_pkg::ST_OVF}},
      '{rasr_pkg::MODE_ADD, 32'd0, 32'd7, 32'd0, -32'd3, 1, '{0, 1, rasr_pkg::ST_OK}},
      '{rasr_pkg::MODE_SUB, 32'd3, 32'd4, 32'd3, 32'd4, 1, '{0, 1, rasr_pkg::ST_OK}},
      '{MODE_RED, -32'd6, -32'd4, 32'd0, 32'd0, 1, '{3, 2, rasr_pkg::ST_OK}},
      '{MODE_RED, 32'd6, -32'd4, 32'd0, 32'd0, 1, '{-32'd3, 2, rasr_pkg::ST_OK}},
      '{MODE_RED, 32'h7FFF_FFFF, 32'h8000_0001, 32'd0, 32'd0, 1,
        '{-32'd1, 1, rasr_pkg::ST_OK}},
      '{rasr_pkg::MODE_ADD, 32'd1, 32'd65536, 32'd1, 32'd65537, 0,
        '{0, 1, rasr_pkg::ST_OK}},
      '{rasr_pkg::MODE_ADD, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFE, 0,
        '{0, 1, rasr_pkg::ST_OK}},
      '{rasr_pkg::MODE_SUB, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -32'd1, 32'd2, 0,
        '{0, 1, rasr_pkg::ST_OK}},
      '{rasr_pkg::MODE_ADD, 32'd1, 32'd6, 32'd1, 32'd3, 0, '{0, 1, rasr_pkg::ST_OK}},
      '{rasr_pkg::MODE_SUB, -32'd7, 32'd12, 32'd5, -32'd18, 0,
        '{0, 1, rasr_pkg::ST_OK}},
      '{MODE_ALT, 32'h8000_0001, 32'd3, 32'd0, 32'd0, 0, '{0, 1, rasr_pkg::ST_OK}},
      '{rasr_pkg::MODE_ADD, 32'h3FFF_FFFF, 32'd1, 32'h4000_0000, 32'd1, 0,
        '{0, 1, rasr_pkg::ST_OK}}
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      exp_r = rows[i].typed ? rows[i].res
            : predict_frac(rows[i].mode, rows[i].n1, rows[i].d1, rows[i].n2, rows[i].d2);
      send_word(rows[i].mode, rows[i].n1, rows[i].d1, rows[i].n2, rows[i].d2, exp_r);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle = 0;  snk_idle = 0;  end
        1: begin src_idle = 56; snk_idle = 0;  end
        2: begin src_idle = 0;  snk_idle = 56; end
        default: begin src_idle = 24; snk_idle = 24; end
      endcase
      for (int i = 0; i < 200; i++) begin
        md = 2'($urandom_range(3));
        k = $urandom_range(99);
        if (k < 55) begin
          n1 = rand_val(0); d1 = rand_den(1000);
          n2 = rand_val(0); d2 = rand_den(1000);
        end else if (k < 75) begin
          n1 = rand_val(1); d1 = rand_den(65535);
          n2 = rand_val(0); d2 = rand_den(300);
        end else if (k < 85) begin
          n1 = rand_val(2); d1 = rand_val(3);
          n2 = rand_val(3); d2 = rand_val(2);
        end else if (k < 92) begin
          // common factors so the reduction has work to do
          n1 = rand_val(0) * 36; d1 = rand_den(200) * 24;
          n2 = rand_val(0) * 10; d2 = rand_den(200) * 15;
        end else begin
          n1 = $urandom_range(1) ? 32'd0 : rand_val(0);
          d1 = $urandom_range(2) ? rand_den(50) : 32'd0;
          n2 = rand_val(0);
          d2 = $urandom_range(2) ? rand_den(50) : 32'd0;
        end
        send_word(md, n1, d1, n2, d2, predict_frac(md, n1, d1, n2, d2));
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    snk_idle = 0;
    while (sum_q.size() != 0) @(posedge clk_i);
    repeat (6000) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("rational_add_sub_reduce_top_test: clean");
    end else begin
      $display("rational_add_sub_reduce_top_test: errors");
    end
    $finish;
  end

endmodule
